@@ sv/bfls_pkg.sv @@
// ----------------------------------------------------------------------------
// bfls_pkg: shared definitions for the button fan level selector
// Register indexes, reset values, the duty level table and its lookup.
// ----------------------------------------------------------------------------
package bfls_pkg;

  localparam int unsigned TICK_W    = 16;
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned DUTY_W    = 9;
  localparam int unsigned STORED_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  // Levels the design may use, and the length of the duty table
  localparam int unsigned NUM_LEVELS = 6;
  localparam int unsigned TABLE_LEN  = 6;
  localparam int unsigned LEVEL_LIM_I =
      (NUM_LEVELS < TABLE_LEN) ? ((NUM_LEVELS < 1) ? 1 : NUM_LEVELS) : TABLE_LEN;
  localparam logic [LEVEL_W-1:0] LEVEL_LIM = LEVEL_W'(LEVEL_LIM_I);

  localparam logic [TICK_W-1:0]  DEBOUNCE_RST    = 16'd50;
  localparam logic [TICK_W-1:0]  STANDBY_RST     = 16'd3000;
  localparam logic [TICK_W-1:0]  SAVE_RST        = 16'd8000;
  localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RST = 3'd6;
  localparam logic [TICK_W-1:0]  ELAPSED_SAT     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE    = 2'd0,
    REG_STANDBY     = 2'd1,
    REG_SAVE        = 2'd2,
    REG_LEVEL_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_BOOT = 1'b1
  } op_t;

  function automatic logic [DUTY_W-1:0] duty_lookup(input logic [LEVEL_W-1:0] lvl);
    logic [DUTY_W-1:0] d;
    unique case (lvl)
      3'd0:    d = 9'd130;
      3'd1:    d = 9'd168;
      3'd2:    d = 9'd206;
      3'd3:    d = 9'd244;
      3'd4:    d = 9'd282;
      3'd5:    d = 9'd320;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

@@ sv/button_fan_level_selector.sv @@
// ----------------------------------------------------------------------------
// button_fan_level_selector: push button stepping of fan duty levels
// Debounce, level advance, long-hold standby and delayed save request.
// ----------------------------------------------------------------------------
// The result of an accepted request is written into the output register in the cycle after acceptance.
// Throughput: one request per cycle; the output register takes a new result in
// the same cycle the previous one is taken, so only output backpressure stalls.
// Reset (synchronous, active high): registers to their default values, the tick
// counter saturated, all flags and the level cleared, output register empty.
module button_fan_level_selector
  import bfls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // [0] button_level, [8:1] stored_level
  input  logic                 s_axis_tuser,  // [0] op
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata   // [8:0] duty, [11:9] level_index,
                                              // [12] in_standby, [13] save_strobe
);

  // Configuration registers
  logic [TICK_W-1:0]  debounce_ticks;
  logic [TICK_W-1:0]  standby_ticks;
  logic [TICK_W-1:0]  save_ticks;
  logic [LEVEL_W-1:0] level_count;

  // Selector state
  logic [TICK_W-1:0]  elapsed,       elapsed_next;
  logic               pressed_flag,  pressed_flag_next;
  logic               standby_flag,  standby_flag_next;
  logic               save_pending,  save_pending_next;
  logic [LEVEL_W-1:0] current_level, current_level_next;
  logic [DUTY_W-1:0]  duty_reg,      duty_reg_next;
  logic               strobe;

  // Output register
  logic        out_valid;
  logic [15:0] out_data;

  logic                button;
  logic [STORED_W-1:0] stored;
  logic                accept;
  logic [LEVEL_W-1:0]  eff_count;
  logic [LEVEL_W:0]    level_inc;
  logic [TICK_W-1:0]   elapsed_inc;

  assign button = s_axis_tdata[0];
  assign stored = s_axis_tdata[STORED_W:1];

  // Take a request whenever the output register is empty or being drained
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Clamp the level count into 1..limit
  always_comb begin
    if (level_count == '0) begin
      eff_count = LEVEL_W'(1);
    end else if (level_count > LEVEL_LIM) begin
      eff_count = LEVEL_LIM;
    end else begin
      eff_count = level_count;
    end
  end

  // Saturating tick count
  assign elapsed_inc = (elapsed == ELAPSED_SAT) ? elapsed : elapsed + TICK_W'(1);
  assign level_inc   = {1'b0, current_level} + (LEVEL_W+1)'(1);

  // Next state: the checks run in order, each one seeing the previous result
  always_comb begin
    elapsed_next       = elapsed;
    pressed_flag_next  = pressed_flag;
    standby_flag_next  = standby_flag;
    save_pending_next  = save_pending;
    current_level_next = current_level;
    duty_reg_next      = duty_reg;
    strobe             = 1'b0;

    unique case (op_t'(s_axis_tuser))
      OP_BOOT: begin
        // Load the stored level, drop it if outside the levels in use
        if (stored >= {{(STORED_W-LEVEL_W){1'b0}}, eff_count}) begin
          current_level_next = '0;
        end else begin
          current_level_next = stored[LEVEL_W-1:0];
        end
        duty_reg_next = duty_lookup(current_level_next);
      end
      default: begin
        elapsed_next = elapsed_inc;
        if (elapsed_inc > debounce_ticks) begin
          // press
          if (!pressed_flag && !button) begin
            pressed_flag_next = 1'b1;
            elapsed_next      = '0;
          end
          // long hold enters standby
          if (pressed_flag_next && elapsed_next > standby_ticks) begin
            standby_flag_next = 1'b1;
            duty_reg_next     = '0;
          end
          // release: short press advances the level, or only wakes from standby
          if (pressed_flag_next && button) begin
            if (elapsed_next <= standby_ticks) begin
              if (!standby_flag_next) begin
                if (level_inc >= {1'b0, eff_count}) begin
                  current_level_next = '0;
                end else begin
                  current_level_next = level_inc[LEVEL_W-1:0];
                end
              end
              duty_reg_next     = duty_lookup(current_level_next);
              save_pending_next = 1'b1;
              standby_flag_next = 1'b0;
            end
            pressed_flag_next = 1'b0;
            elapsed_next      = '0;
          end
        end
        // save request once the button has been idle long enough
        if (save_pending_next && elapsed_next > save_ticks) begin
          strobe            = 1'b1;
          save_pending_next = 1'b0;
        end
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RST;
      standby_ticks  <= STANDBY_RST;
      save_ticks     <= SAVE_RST;
      level_count    <= LEVEL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:    debounce_ticks <= cfg_data[TICK_W-1:0];
        REG_STANDBY:     standby_ticks  <= cfg_data[TICK_W-1:0];
        REG_SAVE:        save_ticks     <= cfg_data[TICK_W-1:0];
        REG_LEVEL_COUNT: level_count    <= cfg_data[LEVEL_W-1:0];
        default:         ;
      endcase
    end
  end

  // Advance state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed       <= ELAPSED_SAT;
      pressed_flag  <= 1'b0;
      standby_flag  <= 1'b0;
      save_pending  <= 1'b0;
      current_level <= '0;
      duty_reg      <= '0;
    end else if (accept) begin
      elapsed       <= elapsed_next;
      pressed_flag  <= pressed_flag_next;
      standby_flag  <= standby_flag_next;
      save_pending  <= save_pending_next;
      current_level <= current_level_next;
      duty_reg      <= duty_reg_next;
    end
  end

  // Output register: hold until taken, reload on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {2'b00, strobe, standby_flag_next, current_level_next, duty_reg_next};
    end
  end

endmodule
